FILE: rtl/thfs_pkg.sv
// Shared types and constants for the two-hand fixture sequencer.
// No dependencies; imported by two_hand_fixture_sequencer and its test bench.

package thfs_pkg;

	// Widths of the streams and of the configuration port
	localparam int unsigned IN_TDATA_W  = 8;
	localparam int unsigned OUT_TDATA_W = 16;
	localparam int unsigned CFG_IDX_W   = 2;
	localparam int unsigned CFG_DATA_W  = 8;
	localparam int unsigned CNT_W       = 8;

	// Register reset values
	localparam logic [CFG_DATA_W-1:0] PAIR_WINDOW_RST = 8'd100;
	localparam logic [CFG_DATA_W-1:0] SETTLE_RST      = 8'd100;
	localparam logic [CFG_DATA_W-1:0] CONFIRM_RST     = 8'd20;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PAIR_WINDOW = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SETTLE      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CONFIRM     = 2'd2;

	// Sequencer step, also reported as phase
	typedef enum logic [2:0] {
		ST_STANDBY     = 3'd0,
		ST_CARRIER_IN  = 3'd1,
		ST_CLOSE_DOOR  = 3'd2,
		ST_OPEN_DOOR   = 3'd3,
		ST_CARRIER_OUT = 3'd4
	} step_t;

	// Sub-phase codes: standby meaning and drive meaning share the field
	localparam logic [1:0] SB_IDLE         = 2'd0;
	localparam logic [1:0] SB_WINDOW       = 2'd1;
	localparam logic [1:0] SB_CONFIRM      = 2'd2;
	localparam logic [1:0] SB_WAIT_RELEASE = 2'd3;
	localparam logic [1:0] DRV_EVAL        = 2'd0;
	localparam logic [1:0] DRV_SETTLE      = 2'd1;

	// Valve bit positions
	localparam int unsigned V_CIN    = 0;
	localparam int unsigned V_COUT   = 1;
	localparam int unsigned V_DCLOSE = 2;
	localparam int unsigned V_DOPEN  = 3;

endpackage

FILE: rtl/two_hand_fixture_sequencer.sv
// Two-hand start and cylinder sequencer for a test fixture, one tick per item.
// Depends on thfs_pkg (types, register indexes, valve bit positions).

// The block takes one item per one-millisecond tick on the slave stream and returns
// exactly one result item for it on the master stream. A start needs the carrier out and
// the door up, and both keys pressed either within pair_window_ticks of each other or
// together and held for confirm_ticks; a lone key that times out raises release_warning
// until it is let go. Holding both keys drives the carrier in and then the door closed,
// each drive settling for settle_ticks before its sensor is checked; a closed door gives
// one tick of ready_pulse and lamps_off. Releasing a key backs out: door open, carrier
// out. Rate: one item per clock cycle while the skid register is empty, and each result
// is registered. The per-tick state update is a single pass of logic from the state
// registers into the output buffer; this two-entry buffer (result register plus skid
// register) lets the slave side keep accepting while one result waits to be taken.
// Configuration writes (cfg_we, cfg_index, cfg_data) land at the next clock edge;
// index three is ignored.

module two_hand_fixture_sequencer
	import thfs_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	// Input ticks
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// [0] key_one_pressed, [1] key_two_pressed, [2] part_in_sensor,
	// [3] part_out_sensor, [4] door_up_sensor, [5] door_down_sensor, [7:6] zero
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// Results
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// [0] carrier_in_valve, [1] carrier_out_valve, [2] door_close_valve,
	// [3] door_open_valve, [6:4] phase, [7] ready_pulse, [8] lamps_off,
	// [9] release_warning, [15:10] zero
	output logic [OUT_TDATA_W-1:0] m_tdata,
	// Configuration
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	// Configuration registers
	logic [CFG_DATA_W-1:0] pair_window_q, settle_q, confirm_q;

	// Sequencer state
	step_t            step_q;
	logic [1:0]       sub_q;
	logic [CNT_W-1:0] cnt_q;
	logic [3:0]       valve_q;
	logic             first_key_q;

	// Output buffer
	logic                   out_valid_q, skid_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q, skid_data_q;

	logic accept, pop;

	// Next-state values
	step_t            n_step;
	logic [1:0]       n_sub;
	logic [CNT_W-1:0] n_cnt;
	logic [3:0]       n_valve;
	logic             n_first;
	logic             n_ready, n_warn;
	logic [OUT_TDATA_W-1:0] result;

	// Decoded inputs
	logic k1, k2, pin, pout, dup, ddown;
	logic both, c_inside, c_outside, d_up, d_down;

	// Shared drive-step controls
	logic             drv_cond, drv_ok, drv_success;
	step_t            drv_other, drv_next;
	logic [3:0]       drv_set, drv_clr;
	logic [CNT_W-1:0] cnt_bump;
	logic [CNT_W-1:0] win_bump;
	logic             held;

	assign s_tready = !skid_valid_q;
	assign accept   = s_tvalid && s_tready;
	assign pop      = out_valid_q && m_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	assign k1    = s_tdata[0];
	assign k2    = s_tdata[1];
	assign pin   = s_tdata[2];
	assign pout  = s_tdata[3];
	assign dup   = s_tdata[4];
	assign ddown = s_tdata[5];

	// A sensor pair that reads both or neither is an undefined position
	assign both      = k1 && k2;
	assign c_inside  = pin && !pout;
	assign c_outside = pout && !pin;
	assign d_up      = dup && !ddown;
	assign d_down    = ddown && !dup;

	// Saturating tick count
	assign cnt_bump = (cnt_q == {CNT_W{1'b1}}) ? cnt_q : cnt_q + 1'b1;

	// Pick the key condition, valves and sensor of the current drive step
	always_comb begin
		drv_cond  = both;
		drv_other = ST_STANDBY;
		drv_next  = ST_STANDBY;
		drv_set   = 4'b0000;
		drv_clr   = 4'b0000;
		drv_ok    = 1'b0;
		unique case (step_q)
			ST_CARRIER_IN: begin
				drv_cond  = both;
				drv_other = ST_CARRIER_OUT;
				drv_set   = 4'b0001 << V_CIN;
				drv_clr   = 4'b0001 << V_COUT;
				drv_ok    = c_inside;
				drv_next  = ST_CLOSE_DOOR;
			end
			ST_CLOSE_DOOR: begin
				drv_cond  = both;
				drv_other = ST_OPEN_DOOR;
				drv_set   = 4'b0001 << V_DCLOSE;
				drv_clr   = 4'b0001 << V_DOPEN;
				drv_ok    = d_down;
				drv_next  = ST_STANDBY;
			end
			ST_OPEN_DOOR: begin
				drv_cond  = !both;
				drv_other = ST_CLOSE_DOOR;
				drv_set   = 4'b0001 << V_DOPEN;
				drv_clr   = 4'b0001 << V_DCLOSE;
				drv_ok    = d_up;
				drv_next  = ST_CARRIER_OUT;
			end
			ST_CARRIER_OUT: begin
				drv_cond  = !both;
				drv_other = ST_CARRIER_IN;
				drv_set   = 4'b0001 << V_COUT;
				drv_clr   = 4'b0001 << V_CIN;
				drv_ok    = c_outside;
				drv_next  = ST_STANDBY;
			end
			default: begin
				drv_cond = both;
			end
		endcase
	end

	// One tick of the sequencer
	always_comb begin
		n_step      = step_q;
		n_sub       = sub_q;
		n_cnt       = cnt_q;
		n_valve     = valve_q;
		n_first     = first_key_q;
		n_ready     = 1'b0;
		n_warn      = 1'b0;
		drv_success = 1'b0;
		win_bump    = cnt_bump;
		held        = 1'b0;

		// An unreachable step code falls back to standby idle
		if (step_q > ST_CARRIER_OUT) begin
			n_step   = ST_STANDBY;
			n_sub    = SB_IDLE;
			n_cnt    = '0;
			win_bump = 8'd1;
		end

		if (n_step == ST_STANDBY) begin
			priority case (n_sub)
				SB_IDLE: begin
					if (c_outside && d_up) begin
						if (k1 != k2) begin
							n_first = k2;
							n_sub   = SB_WINDOW;
							n_cnt   = '0;
						end else if (both) begin
							n_sub = SB_CONFIRM;
							n_cnt = '0;
						end
					end
				end
				SB_WINDOW: begin
					n_cnt = win_bump;
					if (both) begin
						n_step = ST_CARRIER_IN;
						n_sub  = DRV_EVAL;
						n_cnt  = '0;
					end else if (win_bump >= pair_window_q) begin
						n_sub = SB_WAIT_RELEASE;
						n_cnt = '0;
					end
				end
				SB_CONFIRM: begin
					n_cnt = win_bump;
					if (win_bump >= confirm_q) begin
						n_cnt = '0;
						if (both) begin
							n_step = ST_CARRIER_IN;
							n_sub  = DRV_EVAL;
						end else begin
							n_sub = SB_IDLE;
						end
					end
				end
				default: begin
				end
			endcase
			// Hold the warning until the key pressed first is let go
			if (n_step == ST_STANDBY && n_sub == SB_WAIT_RELEASE) begin
				held = n_first ? k2 : k1;
				if (held) begin
					n_warn = 1'b1;
				end else begin
					n_sub = SB_IDLE;
				end
			end
		end else if (sub_q == DRV_EVAL) begin
			if (!drv_cond) begin
				n_step = drv_other;
			end else begin
				n_valve = (valve_q | drv_set) & ~drv_clr;
				n_sub   = DRV_SETTLE;
				n_cnt   = '0;
			end
		end else begin
			n_cnt = cnt_bump;
			if (cnt_bump >= settle_q) begin
				n_sub = DRV_EVAL;
				n_cnt = '0;
				if (drv_ok) begin
					n_step      = drv_next;
					drv_success = 1'b1;
				end
			end
		end

		if (drv_success && step_q == ST_CLOSE_DOOR) begin
			n_ready = 1'b1;
		end
		if (drv_success) begin
			n_sub = SB_IDLE;
		end

		result      = '0;
		result[3:0] = n_valve;
		result[6:4] = n_step;
		result[7]   = n_ready;
		result[8]   = n_ready;
		result[9]   = n_warn;
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_window_q <= PAIR_WINDOW_RST;
			settle_q      <= SETTLE_RST;
			confirm_q     <= CONFIRM_RST;
		end else if (cfg_we) begin
			if (cfg_index == REG_PAIR_WINDOW) pair_window_q <= cfg_data;
			if (cfg_index == REG_SETTLE)      settle_q      <= cfg_data;
			if (cfg_index == REG_CONFIRM)     confirm_q     <= cfg_data;
		end
	end

	// Advance the sequencer on every accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= ST_STANDBY;
			sub_q       <= SB_IDLE;
			cnt_q       <= '0;
			valve_q     <= '0;
			first_key_q <= 1'b0;
		end else if (accept) begin
			step_q      <= n_step;
			sub_q       <= n_sub;
			cnt_q       <= n_cnt;
			valve_q     <= n_valve;
			first_key_q <= n_first;
		end
	end

	// Output buffer: result register with a skid register behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end
		end else if (accept) begin
			if (out_valid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) out_data_q <= skid_data_q;
		end else if (accept) begin
			if (out_valid_q && !pop) skid_data_q <= result;
			else                     out_data_q  <= result;
		end
	end

	// Checks
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register full while result register empty");

	a_carrier_valves: assert property (@(posedge clk) disable iff (!arst_n)
		!(valve_q[V_CIN] && valve_q[V_COUT]) && !(valve_q[V_DCLOSE] && valve_q[V_DOPEN]))
		else $error("opposing valves driven together");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= ST_CARRIER_OUT)
		else $error("sequencer step out of range");

	a_ready_in_standby: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && n_ready) |=> (step_q == ST_STANDBY && valve_q[V_DCLOSE]))
		else $error("ready pulse without closed door in standby");

endmodule

FILE: tb/sv/two_hand_fixture_sequencer_test.sv
// Self-checking bench for two_hand_fixture_sequencer: operator key and cylinder
// sequences in, predicted valve levels, phase and pulses checked per result item.
// Depends on thfs_pkg and the two_hand_fixture_sequencer RTL.

module two_hand_fixture_sequencer_test;
	import thfs_pkg::*;

	// Longest stretch with no handshake on either side: the forced output hold-off
	// plus stalls and register writes, with a wide margin.
	localparam int QUIET_LIMIT = 2000;
	localparam int SHOWN_FAILS = 10;

	// One input item, highest bit first, laid out as on s_tdata
	typedef struct packed {
		logic [1:0] pad;
		logic       door_down;
		logic       door_up;
		logic       part_out;
		logic       part_in;
		logic       key_two;
		logic       key_one;
	} tick_t;

	// One result item, highest bit first, laid out as on m_tdata
	typedef struct packed {
		logic [5:0] pad;
		logic       release_warning;
		logic       lamps_off;
		logic       ready_pulse;
		logic [2:0] phase;
		logic       door_open;
		logic       door_close;
		logic       carrier_out;
		logic       carrier_in;
	} outputs_t;

	// Where a cylinder sits as seen by its sensor pair; JAMMED reads both sensors
	typedef enum int {AT_HOME, AT_WORK, IN_TRANSIT, JAMMED} travel_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata   = '0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;

	// Shadow of the sequencer: state and registers, all at their reset values
	step_t                 seq_step          = ST_STANDBY;
	logic [1:0]            seq_sub           = SB_IDLE;
	logic [CNT_W-1:0]      seq_count         = '0;
	logic [3:0]            seq_valves        = '0;
	logic                  seq_key_two_first = 1'b0;
	logic [CFG_DATA_W-1:0] win_ticks         = PAIR_WINDOW_RST;
	logic [CFG_DATA_W-1:0] settle_len        = SETTLE_RST;
	logic [CFG_DATA_W-1:0] confirm_len       = CONFIRM_RST;

	tick_t    tick_queue[$];
	outputs_t expected_outputs[$];

	int   planned      = 0;
	int   flip_pct     = 0;
	int   phase_no     = 0;
	int   fail_count   = 0;
	int   results_seen = 0;
	int   quiet_cycles = 0;
	int   src_gap      = 0;
	int   snk_gap      = 0;
	bit   src_steady   = 1'b0;
	bit   snk_steady   = 1'b0;
	logic hold_off     = 1'b0;

	always #1 clk = ~clk;

	two_hand_fixture_sequencer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// ---------------------------------------------------------------- prediction

	// Saturating tick counter
	function automatic void count_tick();
		if (seq_count != '1)
			seq_count++;
	endfunction

	// One cylinder step: drive while cond holds, else hand over to bail_step.
	// After the settle time the sensor decides; true means the step moved on.
	function automatic bit advance_drive(input bit cond, input step_t bail_step,
			input int unsigned set_bit, input int unsigned clr_bit,
			input bit sensor_ok, input step_t next_step);
		if (seq_sub == DRV_EVAL) begin
			if (!cond) begin
				seq_step = bail_step;
				return 1'b0;
			end
			seq_valves[set_bit] = 1'b1;
			seq_valves[clr_bit] = 1'b0;
			seq_sub   = DRV_SETTLE;
			seq_count = '0;
			return 1'b0;
		end
		// Keys are not looked at while settling
		count_tick();
		if (seq_count < settle_len)
			return 1'b0;
		seq_sub   = DRV_EVAL;
		seq_count = '0;
		if (sensor_ok) begin
			seq_step = next_step;
			return 1'b1;
		end
		// Sensor not reached: drive again on the next tick
		return 1'b0;
	endfunction

	// Advance the shadow by one tick and return the result item it produces
	function automatic outputs_t predict_tick(input tick_t t);
		bit       both, c_inside, c_outside, d_up, d_down, ready, warn, held;
		outputs_t r;
		both      = t.key_one && t.key_two;
		// A sensor pair reading both or neither is an undefined position
		c_inside  = t.part_in && !t.part_out;
		c_outside = t.part_out && !t.part_in;
		d_up      = t.door_up && !t.door_down;
		d_down    = t.door_down && !t.door_up;
		ready     = 1'b0;
		warn      = 1'b0;
		case (seq_step)
			ST_STANDBY: begin
				if (seq_sub == SB_IDLE) begin
					// Only a fixture at home may start
					if (c_outside && d_up) begin
						if (t.key_one != t.key_two) begin
							seq_key_two_first = t.key_two;
							seq_sub   = SB_WINDOW;
							seq_count = '0;
						end else if (both) begin
							seq_sub   = SB_CONFIRM;
							seq_count = '0;
						end
					end
				end else if (seq_sub == SB_WINDOW) begin
					count_tick();
					if (both) begin
						seq_step  = ST_CARRIER_IN;
						seq_sub   = DRV_EVAL;
						seq_count = '0;
					end else if (seq_count >= win_ticks) begin
						seq_sub   = SB_WAIT_RELEASE;
						seq_count = '0;
					end
				end else if (seq_sub == SB_CONFIRM) begin
					count_tick();
					if (seq_count >= confirm_len) begin
						seq_count = '0;
						if (both) begin
							seq_step = ST_CARRIER_IN;
							seq_sub  = DRV_EVAL;
						end else begin
							seq_sub = SB_IDLE;
						end
					end
				end
				// Rejected start: warn until the key that came first is let go
				if (seq_step == ST_STANDBY && seq_sub == SB_WAIT_RELEASE) begin
					held = seq_key_two_first ? t.key_two : t.key_one;
					if (held)
						warn = 1'b1;
					else
						seq_sub = SB_IDLE;
				end
			end
			ST_CARRIER_IN: begin
				void'(advance_drive(both, ST_CARRIER_OUT, V_CIN, V_COUT, c_inside,
					ST_CLOSE_DOOR));
			end
			ST_CLOSE_DOOR: begin
				ready = advance_drive(both, ST_OPEN_DOOR, V_DCLOSE, V_DOPEN, d_down,
					ST_STANDBY);
				if (ready)
					seq_sub = SB_IDLE;
			end
			ST_OPEN_DOOR: begin
				void'(advance_drive(!both, ST_CLOSE_DOOR, V_DOPEN, V_DCLOSE, d_up,
					ST_CARRIER_OUT));
			end
			default: begin
				if (advance_drive(!both, ST_CARRIER_IN, V_COUT, V_CIN, c_outside,
						ST_STANDBY))
					seq_sub = SB_IDLE;
			end
		endcase
		r                 = '0;
		r.carrier_in      = seq_valves[V_CIN];
		r.carrier_out     = seq_valves[V_COUT];
		r.door_close      = seq_valves[V_DCLOSE];
		r.door_open       = seq_valves[V_DOPEN];
		r.phase           = seq_step;
		r.ready_pulse     = ready;
		r.lamps_off       = ready;
		r.release_warning = warn;
		return r;
	endfunction

	// ---------------------------------------------------------------- stimulus

	function automatic tick_t make_tick(input bit k1, input bit k2,
			input travel_t carrier, input travel_t door);
		tick_t t;
		t           = '0;
		t.key_one   = k1;
		t.key_two   = k2;
		t.part_out  = (carrier == AT_HOME) || (carrier == JAMMED);
		t.part_in   = (carrier == AT_WORK) || (carrier == JAMMED);
		t.door_up   = (door == AT_HOME) || (door == JAMMED);
		t.door_down = (door == AT_WORK) || (door == JAMMED);
		return t;
	endfunction

	// Queue one item; in the random part, now and then flip a bit as pin noise
	task automatic push_tick(input tick_t t);
		int b;
		if ($urandom_range(0, 99) < flip_pct) begin
			b    = $urandom_range(0, 5);
			t[b] = ~t[b];
		end
		tick_queue.push_back(t);
		planned++;
	endtask

	// One operator attempt with random timing: a start, the drive in, the back-out.
	// Sensors follow the valves loosely so that checks both pass and fail.
	task automatic plan_operator_cycle();
		int      style, hold, span, t_c, t_d, t_u, t_o, rp, rl, i;
		bit      k1, k2, rel1, rel2;
		travel_t cp, dp;
		repeat ($urandom_range(1, 4)) push_tick(make_tick(0, 0, AT_HOME, AT_HOME));
		style = $urandom_range(0, 9);
		if (style == 9) begin
			// Raw noise on every pin
			repeat ($urandom_range(3, 15)) push_tick(tick_t'({2'b00, 6'($urandom)}));
			return;
		end
		if (style == 8) begin
			// Both keys while a sensor pair is undefined or away from home
			cp = travel_t'($urandom_range(1, 3));
			dp = travel_t'($urandom_range(0, 3));
			repeat ($urandom_range(1, 5)) push_tick(make_tick(1, 1, cp, dp));
			repeat (2) push_tick(make_tick(0, 0, AT_HOME, AT_HOME));
			return;
		end
		if (style >= 6) begin
			// Both keys together: confirm, or let go before the confirm tick
			if ($urandom_range(0, 3) == 0) begin
				repeat ($urandom_range(1, confirm_len))
					push_tick(make_tick(1, 1, AT_HOME, AT_HOME));
				repeat (2) push_tick(make_tick(0, 0, AT_HOME, AT_HOME));
				return;
			end
			repeat (confirm_len) push_tick(make_tick(1, 1, AT_HOME, AT_HOME));
		end else begin
			// One key leads; odd styles lead with key two
			k1 = !style[0];
			k2 = style[0];
			if ($urandom_range(0, 4) == 0) begin
				// Window lapses: hold the lone key through the warning, then release
				repeat (win_ticks + 1 + $urandom_range(0, 3))
					push_tick(make_tick(k1, k2, AT_HOME, AT_HOME));
				repeat ($urandom_range(1, 3)) push_tick(make_tick(0, 0, AT_HOME, AT_HOME));
				return;
			end
			repeat ($urandom_range(1, win_ticks))
				push_tick(make_tick(k1, k2, AT_HOME, AT_HOME));
		end

		// Both keys held: carrier in, then door down. Mostly long enough to finish.
		span = 3 + 2 * settle_len;
		t_c  = $urandom_range(1, settle_len + 2);
		t_d  = settle_len + 2 + $urandom_range(0, settle_len + 1);
		hold = ($urandom_range(0, 9) < 7) ? span + $urandom_range(0, 8)
			: $urandom_range(1, span);
		cp = AT_HOME;
		dp = AT_HOME;
		for (i = 0; i < hold; i++) begin
			cp = (i >= t_c) ? AT_WORK : (i + 1 == t_c) ? IN_TRANSIT : AT_HOME;
			dp = (i >= t_d) ? AT_WORK : (i + 1 == t_d) ? IN_TRANSIT : AT_HOME;
			push_tick(make_tick(1, 1, cp, dp));
		end

		// Release: door back up, then carrier out; sometimes one key stays down,
		// sometimes both come back for a moment to reverse the back-out.
		rel1 = ($urandom_range(0, 5) == 0);
		rel2 = !rel1 && ($urandom_range(0, 4) == 0);
		t_u  = $urandom_range(1, settle_len + 2);
		t_o  = t_u + $urandom_range(1, settle_len + 2);
		span = 3 + 2 * settle_len + $urandom_range(0, 6);
		rp   = ($urandom_range(0, 4) == 0) ? $urandom_range(0, span - 1) : span;
		rl   = $urandom_range(1, 4);
		for (i = 0; i < span; i++) begin
			if (i >= rp && i < rp + rl)
				push_tick(make_tick(1, 1, (i >= t_o) ? AT_HOME : cp,
					(i >= t_u) ? AT_HOME : dp));
			else
				push_tick(make_tick(rel1, rel2, (i >= t_o) ? AT_HOME : cp,
					(i >= t_u) ? AT_HOME : dp));
		end
	endtask

	// Block until nothing is queued, offered or outstanding
	task automatic wait_drained();
		while (tick_queue.size() != 0 || s_tvalid || expected_outputs.size() != 0)
			@(negedge clk);
	endtask

	// Write all three registers on back-to-back edges while the block is idle
	task automatic write_registers(input logic [CFG_DATA_W-1:0] window,
			input logic [CFG_DATA_W-1:0] settle, input logic [CFG_DATA_W-1:0] confirm);
		wait_drained();
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_PAIR_WINDOW;
		cfg_data  <= window;
		win_ticks  = window;
		@(posedge clk);
		cfg_index <= REG_SETTLE;
		cfg_data  <= settle;
		settle_len = settle;
		@(posedge clk);
		cfg_index  <= REG_CONFIRM;
		cfg_data   <= confirm;
		confirm_len = confirm;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// The queue is empty on entry; drop the tail of the last attempt so that
	// long register settings do not stretch the phase
	task automatic fill_phase(input int target);
		planned = 0;
		while (planned < target)
			plan_operator_cycle();
		while (tick_queue.size() > target)
			void'(tick_queue.pop_back());
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin : run_sequence
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: short registers so every path fits in a few ticks
		write_registers(8'd2, 8'd2, 8'd2);
		push_tick(tick_t'(8'h00));                         // every pin low
		push_tick(tick_t'(8'h3F));                         // every pin high, pairs undefined
		push_tick(make_tick(0, 0, AT_HOME, AT_HOME));
		push_tick(make_tick(1, 0, AT_HOME, AT_HOME));      // key one leads
		push_tick(make_tick(1, 1, AT_HOME, AT_HOME));      // pair inside window
		push_tick(make_tick(1, 1, AT_HOME, AT_HOME));      // drive carrier in
		push_tick(make_tick(1, 1, AT_WORK, AT_HOME));
		push_tick(make_tick(1, 1, AT_WORK, AT_HOME));      // carrier in confirmed
		push_tick(make_tick(1, 1, AT_WORK, AT_HOME));      // drive door down
		push_tick(make_tick(1, 1, AT_WORK, AT_WORK));
		push_tick(make_tick(1, 1, AT_WORK, AT_WORK));      // door closed: ready
		push_tick(make_tick(0, 0, AT_HOME, AT_HOME));
		push_tick(make_tick(0, 1, AT_HOME, AT_HOME));      // key two leads
		push_tick(make_tick(0, 1, AT_HOME, AT_HOME));
		push_tick(make_tick(0, 1, AT_HOME, AT_HOME));      // window lapses, warn
		push_tick(make_tick(0, 1, AT_HOME, AT_HOME));
		push_tick(make_tick(1, 0, AT_HOME, AT_HOME));      // leading key let go
		push_tick(make_tick(1, 1, AT_HOME, AT_HOME));      // simultaneous press
		push_tick(make_tick(1, 1, AT_HOME, AT_HOME));
		push_tick(make_tick(1, 1, AT_HOME, AT_HOME));      // confirmed
		push_tick(make_tick(1, 1, AT_HOME, AT_HOME));      // drive carrier in
		push_tick(make_tick(0, 0, AT_HOME, AT_HOME));      // keys ignored while settling
		push_tick(make_tick(0, 0, AT_HOME, AT_HOME));      // sensor check fails
		push_tick(make_tick(0, 0, AT_HOME, AT_HOME));      // released: back out
		push_tick(make_tick(0, 0, AT_HOME, AT_HOME));      // drive carrier out
		push_tick(make_tick(0, 0, AT_HOME, AT_HOME));
		push_tick(make_tick(0, 0, AT_HOME, AT_HOME));      // home again

		// Random phases over several register settings, extremes included
		flip_pct = 3;
		write_registers(8'd1, 8'd1, 8'd1);
		phase_no = 1;
		fill_phase(250);
		write_registers(8'd255, 8'd255, 8'd255);
		phase_no = 2;
		fill_phase(300);
		write_registers(8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)),
			8'($urandom_range(1, 6)));
		phase_no = 3;
		fill_phase(300);
		write_registers(8'($urandom_range(1, 255)), 8'($urandom_range(1, 12)),
			8'($urandom_range(1, 30)));
		phase_no = 4;
		fill_phase(250);

		wait_drained();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Stall the result side for a long stretch so the block backs up into its input
	initial begin : long_backpressure
		wait (phase_no == 3);
		repeat (40) @(posedge clk);
		hold_off <= 1'b1;
		repeat (150) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin : watchdog
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("Some tests failed");
		$finish;
	end

	// ---------------------------------------------------------------- driver

	// Offer queued items; after each item, pause for a randomly drawn gap unless in a steady run
	always @(posedge clk) begin : feed_ticks
		int gap_draw;
		if (arst_n && (!s_tvalid || s_tready)) begin
			if (src_gap != 0) begin
				s_tvalid <= 1'b0;
				src_gap  <= src_gap - 1;
			end else if (tick_queue.size() != 0) begin
				if ($urandom_range(0, 29) == 0)
					src_steady = !src_steady;
				gap_draw = src_steady ? 0 : $urandom_range(0, 12);
				s_tvalid <= 1'b1;
				s_tdata  <= tick_queue.pop_front();
				src_gap  <= gap_draw;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Take results; after each one, hold ready low for a randomly drawn gap unless steady
	always @(posedge clk) begin : take_results
		int stall_draw;
		if (arst_n) begin
			if (hold_off) begin
				m_tready <= 1'b0;
			end else if (snk_gap != 0) begin
				m_tready <= 1'b0;
				snk_gap  <= snk_gap - 1;
			end else if (m_tready && m_tvalid) begin
				if ($urandom_range(0, 29) == 0)
					snk_steady = !snk_steady;
				stall_draw = snk_steady ? 0 : $urandom_range(0, 12);
				m_tready <= (stall_draw == 0);
				snk_gap  <= (stall_draw == 0) ? 0 : stall_draw - 1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------- monitor

	// Predict on every accepted item, compare every accepted result with the oldest
	// prediction, and count cycles with no handshake for the watchdog.
	always @(posedge clk) begin : check_results
		outputs_t got, want;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				expected_outputs.push_back(predict_tick(s_tdata));
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (expected_outputs.size() == 0) begin
					fail_count++;
					if (fail_count <= SHOWN_FAILS)
						$display("result %0d arrived with none expected: %h",
							results_seen, got);
				end else begin
					want = expected_outputs.pop_front();
					if (got.carrier_in !== want.carrier_in
							|| got.carrier_out !== want.carrier_out
							|| got.door_close !== want.door_close
							|| got.door_open !== want.door_open
							|| got.phase !== want.phase
							|| got.ready_pulse !== want.ready_pulse
							|| got.lamps_off !== want.lamps_off
							|| got.release_warning !== want.release_warning
							|| got.pad !== want.pad) begin
						fail_count++;
						if (fail_count <= SHOWN_FAILS)
							$display({"result %0d mismatch: expected valves(open,close,out,in)=",
								"%b%b%b%b phase=%0d ready=%b lamps=%b warn=%b pad=%h, ",
								"got %b%b%b%b phase=%0d ready=%b lamps=%b warn=%b pad=%h"},
								results_seen,
								want.door_open, want.door_close, want.carrier_out,
								want.carrier_in, want.phase, want.ready_pulse,
								want.lamps_off, want.release_warning, want.pad,
								got.door_open, got.door_close, got.carrier_out,
								got.carrier_in, got.phase, got.ready_pulse,
								got.lamps_off, got.release_warning, got.pad);
					end
				end
				results_seen++;
			end
			quiet_cycles <= ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				? 0 : quiet_cycles + 1;
		end
	end

endmodule

FILE: files.f
rtl/thfs_pkg.sv
rtl/two_hand_fixture_sequencer.sv
tb/sv/two_hand_fixture_sequencer_test.sv
